FILE: rtl/core/tcw_pkg.sv
// shared types and constants of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLOR_W = 4;
    localparam int TAB_STEP = 4;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BLANK = 8'h20;

    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd1;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_SET   = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DRAIN,
        S_WRITE,
        S_READ,
        S_RESP
    } state_t;

    typedef struct packed {
        logic take_req;
        logic load_plan;
        logic walk_step;
        logic cell_write;
        logic cap_cell;
        logic load_rsp;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_read;
        logic need_walk;
        logic need_write;
        logic wr_pend;
        logic walk_last;
    } dp_status_t;

endpackage

FILE: rtl/core/tcw_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/tcw_ctrl.sv
// sequencing state machine of the text console writer
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;

    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.need_walk)
                begin
                    state_next = S_WALK;
                end
                else if (status.need_write)
                begin
                    state_next = S_WRITE;
                end
                else if (status.is_read)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_WALK:
            begin
                if (status.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = status.wr_pend ? S_WRITE : S_RESP;
            end
            S_WRITE:
            begin
                state_next = S_RESP;
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        req_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.take_req = req_valid;
            end
            S_EXEC:
            begin
                cmd.load_plan = 1'b1;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
            end
            S_WRITE:
            begin
                cmd.cell_write = 1'b1;
            end
            S_READ:
            begin
                cmd.cap_cell = 1'b1;
            end
            S_RESP:
            begin
                cmd.load_rsp = rsp_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // the walk always ends through the drain cycle that flushes its last copy
    a_walk_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && status.walk_last) |=> state_reg == S_DRAIN)
        else $error("walk did not end in drain");

    a_rsp_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && !rsp_valid_reg) |=> rsp_valid_reg)
        else $error("response not presented");

endmodule

FILE: rtl/core/tcw_datapath.sv
// cursor, cell store, screen walker and response registers
`timescale 1ns / 1ps

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [COLOR_W-1:0] cfg_data,
    input  logic [1:0]         mode,
    input  logic [7:0]         char_code,
    input  logic [6:0]         set_x,
    input  logic [4:0]         set_y,
    output logic [6:0]         cursor_x,
    output logic [4:0]         cursor_y,
    output logic [10:0]        cursor_offset,
    output logic [7:0]         cell_char,
    output logic [COLOR_W-1:0] cell_fg,
    output logic [COLOR_W-1:0] cell_bg
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int AW1   = AW + 1;
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int TW    = CW + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int OW    = $clog2(CELLS + 1);
    localparam int XW    = (CW > 7) ? CW : 7;
    localparam int YW    = (RW > 5) ? RW : 5;
    localparam int FW    = (OW > 11) ? OW : 11;
    localparam int DW    = 8 + 2 * COLOR_W;

    // request latch
    mode_t        mode_reg;
    logic [7:0]   char_reg;
    logic [6:0]   setx_reg;
    logic [4:0]   sety_reg;

    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    // plan of the current request
    logic [CW-1:0] plan_col;
    logic [RW-1:0] plan_row;
    logic          plan_walk;
    logic          plan_scroll;
    logic          plan_write;
    logic          plan_inc;
    logic [7:0]    plan_char;
    logic          row_bottom;
    logic [RW-1:0] row_adv;
    logic [TW-1:0] tab_sum;
    logic [CW-1:0] set_col;
    logic [RW-1:0] sat_row;
    logic [CW-1:0] rd_col;

    logic          wr_pend_reg;
    logic          wr_inc_reg;
    logic [7:0]    wr_char_reg;

    // screen walker and its write-back stage
    logic [AW-1:0] walk_idx_reg;
    logic          walk_scroll_reg;
    logic [AW-1:0] walk_src;
    logic          walk_copy_now;
    logic          wb_valid_reg;
    logic [AW-1:0] wb_addr_reg;
    logic          wb_copy_reg;

    logic [OW-1:0] cur_off;
    logic [OW-1:0] rd_off;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic [DW-1:0] cell_reg;

    logic [XW-1:0] col_ext;
    logic [YW-1:0] row_ext;
    logic [FW-1:0] off_ext;

    logic [6:0]         rsp_x_reg;
    logic [4:0]         rsp_y_reg;
    logic [10:0]        rsp_off_reg;
    logic [DW-1:0]      rsp_cell_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FG:  fg_reg <= cfg_data;
                CFG_BG:  bg_reg <= cfg_data;
                default: fg_reg <= fg_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_req)
        begin
            mode_reg <= mode_t'(mode);
            char_reg <= char_code;
            setx_reg <= set_x;
            sety_reg <= set_y;
        end
    end

    assign row_bottom = (row_reg == RW'(ROWS - 1));
    assign row_adv    = row_bottom ? row_reg : row_reg + 1'b1;
    assign tab_sum    = {1'b0, col_reg} + TW'(TAB_STEP);
    assign set_col    = (int'(setx_reg) > COLUMNS) ? CW'(COLUMNS) : CW'(setx_reg);
    assign sat_row    = (int'(sety_reg) > ROWS - 1) ? RW'(ROWS - 1) : RW'(sety_reg);
    assign rd_col     = (int'(setx_reg) > COLUMNS - 1) ? CW'(COLUMNS - 1) : CW'(setx_reg);

    always_comb
    begin
        plan_col    = col_reg;
        plan_row    = row_reg;
        plan_walk   = 1'b0;
        plan_scroll = 1'b0;
        plan_write  = 1'b0;
        plan_inc    = 1'b0;
        plan_char   = char_reg;
        case (mode_reg)
            MODE_PUT:
            begin
                case (char_reg)
                    CH_LF:
                    begin
                        plan_col    = '0;
                        plan_row    = row_adv;
                        plan_walk   = row_bottom;
                        plan_scroll = 1'b1;
                    end
                    CH_TAB:
                    begin
                        if (tab_sum >= TW'(COLUMNS))
                        begin
                            plan_col    = '0;
                            plan_row    = row_adv;
                            plan_walk   = row_bottom;
                            plan_scroll = 1'b1;
                        end
                        else
                        begin
                            plan_col = tab_sum[CW-1:0];
                        end
                    end
                    CH_CR:
                    begin
                        plan_col = '0;
                    end
                    CH_BS:
                    begin
                        if (col_reg != '0)
                        begin
                            plan_col   = col_reg - 1'b1;
                            plan_write = 1'b1;
                            plan_char  = CH_BLANK;
                        end
                    end
                    default:
                    begin
                        // late wrap: a pending wrap moves down before the write
                        if (col_reg >= CW'(COLUMNS))
                        begin
                            plan_col    = '0;
                            plan_row    = row_adv;
                            plan_walk   = row_bottom;
                            plan_scroll = 1'b1;
                        end
                        plan_write = 1'b1;
                        plan_inc   = 1'b1;
                    end
                endcase
            end
            MODE_CLEAR:
            begin
                plan_col  = '0;
                plan_row  = '0;
                plan_walk = 1'b1;
            end
            MODE_SET:
            begin
                plan_col = set_col;
                plan_row = sat_row;
            end
            default:
            begin
                plan_col = col_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            wr_pend_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= cmd.walk_step;
            if (cmd.load_plan)
            begin
                col_reg     <= plan_col;
                row_reg     <= plan_row;
                wr_pend_reg <= plan_write;
            end
            else if (cmd.cell_write && wr_inc_reg)
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_plan)
        begin
            wr_inc_reg      <= plan_inc;
            wr_char_reg     <= plan_char;
            walk_idx_reg    <= '0;
            walk_scroll_reg <= plan_scroll;
        end
        else if (cmd.walk_step)
        begin
            walk_idx_reg <= walk_idx_reg + 1'b1;
        end
        wb_addr_reg <= walk_idx_reg;
        wb_copy_reg <= walk_copy_now;
    end

    // scroll copies the cell one row below, the bottom row and clear get blanks
    assign walk_src      = AW'({1'b0, walk_idx_reg} + AW1'(COLUMNS));
    assign walk_copy_now = walk_scroll_reg && (walk_idx_reg < AW'(CELLS - COLUMNS));

    assign cur_off = OW'(row_reg) * OW'(COLUMNS) + OW'(col_reg);
    assign rd_off  = OW'(sat_row) * OW'(COLUMNS) + OW'(rd_col);

    assign ram_we    = wb_valid_reg || cmd.cell_write;
    assign ram_waddr = wb_valid_reg ? wb_addr_reg : cur_off[AW-1:0];
    assign ram_wdata = (wb_valid_reg && wb_copy_reg) ? ram_rdata :
                       {bg_reg, fg_reg, (wb_valid_reg ? CH_BLANK : wr_char_reg)};
    assign ram_raddr = cmd.walk_step ? walk_src : rd_off[AW-1:0];

    tcw_ram #(
        .WIDTH (DW),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_plan)
        begin
            cell_reg <= '0;
        end
        else if (cmd.cap_cell)
        begin
            cell_reg <= ram_rdata;
        end
    end

    assign col_ext = XW'(col_reg);
    assign row_ext = YW'(row_reg);
    assign off_ext = FW'(cur_off);

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_x_reg    <= col_ext[6:0];
            rsp_y_reg    <= row_ext[4:0];
            rsp_off_reg  <= off_ext[10:0];
            rsp_cell_reg <= cell_reg;
        end
    end

    assign cursor_x      = rsp_x_reg;
    assign cursor_y      = rsp_y_reg;
    assign cursor_offset = rsp_off_reg;
    assign cell_char     = rsp_cell_reg[7:0];
    assign cell_fg       = rsp_cell_reg[8 +: COLOR_W];
    assign cell_bg       = rsp_cell_reg[8 + COLOR_W +: COLOR_W];

    assign status.is_read    = (mode_reg == MODE_READ);
    assign status.need_walk  = plan_walk;
    assign status.need_write = plan_write;
    assign status.wr_pend    = wr_pend_reg;
    assign status.walk_last  = (walk_idx_reg == AW'(CELLS - 1));

    // the ram has one write port: walker write-back and cell write never meet
    a_wport: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cell_write |-> !wb_valid_reg)
        else $error("write port conflict");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= RW'(ROWS - 1))
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= CW'(COLUMNS))
        else $error("cursor column out of range");

endmodule

FILE: rtl/core/text_console_writer.sv
// text console writer top level: controller plus datapath
// clear and a put that scrolls take the screen walker over all COLUMNS*ROWS cells,
// moving one cell per cycle through the cell ram and its single write port
// one request at a time; the next is taken the cycle after the response is registered
// reset: cursor to (0,0), colors to 7 on 1; the cell store is not cleared
`timescale 1ns / 1ps

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         mode,
    input  logic [7:0]         char_code,
    input  logic [6:0]         set_x,
    input  logic [4:0]         set_y,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [6:0]         cursor_x,
    output logic [4:0]         cursor_y,
    output logic [10:0]        cursor_offset,
    output logic [7:0]         cell_char,
    output logic [COLOR_W-1:0] cell_fg,
    output logic [COLOR_W-1:0] cell_bg,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [COLOR_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .char_code     (char_code),
        .set_x         (set_x),
        .set_y         (set_y),
        .cursor_x      (cursor_x),
        .cursor_y      (cursor_y),
        .cursor_offset (cursor_offset),
        .cell_char     (cell_char),
        .cell_fg       (cell_fg),
        .cell_bg       (cell_bg)
    );

endmodule
